@@ sv/rbd2x_pkg.sv @@
// Shared types and constants for the 2x2 RGBA box downsampler.
package rbd2x_pkg;

    localparam int CFG_W  = 13;   // width of the size registers
    localparam int CH_W   = 8;    // one color channel
    localparam int PAIR_W = 9;    // sum of two channels
    localparam int PIX_W  = 4 * CH_W;
    localparam int LINE_W = 4 * PAIR_W;
    localparam int IDX_W  = 2;    // configuration register index

    typedef enum logic [IDX_W-1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1
    } cfg_reg_t;

    // Effective image geometry derived from the size registers
    typedef struct packed {
        logic [CFG_W-1:0] w_eff;
        logic [CFG_W-1:0] h_eff;
        logic [CFG_W-2:0] dw_m1;
        logic [CFG_W-2:0] dh_m1;
    } dims_t;

    // Front stage result handed to the vertical stage
    typedef struct packed {
        logic              emit;
        logic              use_line;
        logic              last;
        logic [LINE_W-1:0] pair;
    } front_t;

endpackage

@@ sv/rbd2x_line_ram.sv @@
// Single-port line buffer holding the horizontal pair sums of one even row.
module rbd2x_line_ram
    import rbd2x_pkg::*;
#(
    parameter int ADDR_W = 11
) (
    input  logic              aclk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [LINE_W-1:0] wdata,
    output logic [LINE_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [LINE_W-1:0] mem [DEPTH];
    logic [LINE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/rbd2x_front.sv @@
// Source position counters, horizontal pairing and line buffer addressing.
module rbd2x_front
    import rbd2x_pkg::*;
#(
    parameter int COL_W = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               restart,
    input  logic               accept,
    input  logic [PIX_W-1:0]   pix,
    input  dims_t              dims,
    output front_t             fr,
    output logic               line_we,
    output logic               line_re,
    output logic [COL_W-2:0]   line_addr
);

    localparam int ADDR_W = COL_W - 1;
    localparam int CW     = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;

    logic [COL_W-1:0] col_reg, col_next;
    logic [CFG_W-1:0] row_reg, row_next;
    logic [PIX_W-1:0] left_reg, left_next;

    logic              w_one, h_one, col_last, row_last;
    logic              have_pair, store_left, row_drop;
    logic [ADDR_W-1:0] dc;
    logic [LINE_W-1:0] pair;

    always_comb begin
        w_one    = (dims.w_eff == CFG_W'(1));
        h_one    = (dims.h_eff == CFG_W'(1));
        col_last = (CW'(col_reg) + CW'(1)) >= CW'(dims.w_eff);
        row_last = (CW'(row_reg) + CW'(1)) >= CW'(dims.h_eff);
        dc       = col_reg[COL_W-1:1];

        have_pair  = w_one || col_reg[0];
        // an odd width drops its last (even) column
        store_left = !w_one && !col_reg[0] && !(col_last && dims.w_eff[0]);
        // an odd height drops its last (even) row
        row_drop   = row_last && dims.h_eff[0] && !h_one;

        for (int k = 0; k < 4; k++) begin
            if (w_one) begin
                pair[k*PAIR_W +: PAIR_W] = {pix[k*CH_W +: CH_W], 1'b0};
            end else begin
                pair[k*PAIR_W +: PAIR_W] = PAIR_W'(left_reg[k*CH_W +: CH_W])
                                         + PAIR_W'(pix[k*CH_W +: CH_W]);
            end
        end

        line_we   = accept && have_pair && !h_one && !row_drop && !row_reg[0];
        line_re   = accept && have_pair && !h_one && row_reg[0];
        line_addr = dc;

        fr.emit     = have_pair && (h_one || row_reg[0]);
        fr.use_line = !h_one;
        fr.last     = (row_reg[CFG_W-1:1] == dims.dh_m1)
                   && (CW'(dc) == CW'(dims.dw_m1));
        fr.pair     = pair;

        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;
        if (restart) begin
            col_next  = '0;
            row_next  = '0;
            left_next = '0;
        end else if (accept) begin
            if (store_left) begin
                left_next = pix;
            end
            if (col_last) begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + CFG_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            left_reg <= left_next;
        end
    end

endmodule

@@ sv/rgba_box_downsample_2x.sv @@
// Top level of the 2x2 box-filter RGBA downsampler.
//
// Source pixels enter on the s_ channel in raster order, one request per
// pixel; each 2x2 block produces one averaged pixel on the m_ channel, with
// m_tlast marking the final pixel of the half-size image. Odd dimensions
// drop their last column or row; a dimension of 1 reuses its single line.
// Image size is set through the cfg_ channel (index 0 width, 1 height);
// a write to either size register restarts the image at the top-left corner.
// Throughput: one pixel per cycle while m_tready stays high. The result
// of a completed block passes through the read stage, which waits for the
// line buffer read, and then the vertical add into the output register.
// The line buffer is a single-port RAM of 2**(COL_W-1) entries (MAX_WIDTH/2
// for a power of two), written in even rows and read in odd rows at the same
// column pair. Reset clears the counters, the pipeline valids and sets both
// sizes to 1; the line buffer is not cleared and needs none.
// When m_tready is low, the output register and the read stage hold and
// s_tready drops once both are full; no request is lost.
module rgba_box_downsample_2x
    import rbd2x_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [PIX_W-1:0] s_tdata,   // in_red, in_green, in_blue, in_alpha
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [PIX_W-1:0] m_tdata,   // out_red, out_green, out_blue, out_alpha
    output logic             m_tlast,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int COL_W  = ($clog2(MAX_WIDTH) < 2) ? 2 : $clog2(MAX_WIDTH);
    localparam int ADDR_W = COL_W - 1;

    logic [CFG_W-1:0] width_reg, height_reg;
    dims_t            dims;
    logic             cfg_wr, cfg_restart, accept, s1_adv;

    front_t            fr;
    logic              line_we, line_re;
    logic [ADDR_W-1:0] line_addr;
    logic [LINE_W-1:0] line_rdata;

    logic              s1_valid_reg, s1_use_line_reg, s1_last_reg;
    logic [LINE_W-1:0] s1_pair_reg;
    logic              m_valid_reg, m_last_reg;
    logic [PIX_W-1:0]  m_data_reg, m_data_next;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    // only the size registers restart the image
    assign cfg_restart = cfg_wr && (cfg_index == REG_SOURCE_WIDTH
                                 || cfg_index == REG_SOURCE_HEIGHT);
    assign s1_adv    = !m_valid_reg || m_tready;
    assign s_tready  = !s1_valid_reg || s1_adv;
    assign accept    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_W'(1);
            height_reg <= CFG_W'(1);
        end else if (cfg_wr) begin
            case (cfg_index)
                REG_SOURCE_WIDTH:  width_reg  <= cfg_data;
                REG_SOURCE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (width_reg == '0) begin
            dims.w_eff = CFG_W'(1);
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            dims.w_eff = CFG_W'(MAX_WIDTH);
        end else begin
            dims.w_eff = width_reg;
        end
        dims.h_eff = (height_reg == '0) ? CFG_W'(1) : height_reg;
        dims.dw_m1 = (dims.w_eff[CFG_W-1:1] == '0) ? '0
                   : dims.w_eff[CFG_W-1:1] - (CFG_W-1)'(1);
        dims.dh_m1 = (dims.h_eff[CFG_W-1:1] == '0) ? '0
                   : dims.h_eff[CFG_W-1:1] - (CFG_W-1)'(1);
    end

    rbd2x_front #(
        .COL_W (COL_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .restart   (cfg_restart),
        .accept    (accept),
        .pix       (s_tdata),
        .dims      (dims),
        .fr        (fr),
        .line_we   (line_we),
        .line_re   (line_re),
        .line_addr (line_addr)
    );

    rbd2x_line_ram #(
        .ADDR_W (ADDR_W)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (line_we),
        .re    (line_re),
        .addr  (line_addr),
        .wdata (fr.pair),
        .rdata (line_rdata)
    );

    // Read stage: holds the pair sum while the line buffer data is read out
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= accept && fr.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pair_reg     <= fr.pair;
            s1_use_line_reg <= fr.use_line;
            s1_last_reg     <= fr.last;
        end
    end

    // Vertical sum and truncating mean
    always_comb begin
        logic [PAIR_W:0] vsum;
        for (int k = 0; k < 4; k++) begin
            vsum = (PAIR_W+1)'(line_rdata[k*PAIR_W +: PAIR_W])
                 + (PAIR_W+1)'(s1_pair_reg[k*PAIR_W +: PAIR_W]);
            if (s1_use_line_reg) begin
                m_data_next[k*CH_W +: CH_W] = vsum[PAIR_W:2];
            end else begin
                // single source row: both taps are the same line
                m_data_next[k*CH_W +: CH_W] = s1_pair_reg[k*PAIR_W+1 +: CH_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_valid_reg) begin
            m_data_reg <= m_data_next;
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // Line buffer is never read and written in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(line_we && line_re))
        else $error("line buffer read and write collide");

    // Read stage holds its contents while the output register is blocked
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_pair_reg)))
        else $error("read stage lost a pending result");

    // Output register only fills from a valid read stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s1_valid_reg))
        else $error("output became valid without a source result");

endmodule
